// ===== rtl/core/trapezoidal_position_ramp_core_assert.svh =====
// Assertion macros for the checker file of the ramp core.
`ifndef TRAPEZOIDAL_POSITION_RAMP_CORE_ASSERT_SVH
`define TRAPEZOIDAL_POSITION_RAMP_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define TPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the next clock cycle.
`define TPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tpr_pkg.sv =====
// ----------------------------------------------------------------------------
// tpr_pkg
// Types and constants shared by the trapezoidal position ramp modules.
// ----------------------------------------------------------------------------
`default_nettype none
package tpr_pkg;
	localparam int unsigned CfgW = 31;
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] REG_VEL_LIMIT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_ACC_LIMIT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_DEC_LIMIT = 2'd2;
	localparam logic [CfgW-1:0] CFG_RESET = 31'd65536;
	localparam logic [63:0] SMALL_ERR = 64'd327680;

	// Multiplier operation request
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	// Square-root request
	typedef struct packed {
		logic        start;
		logic [63:0] x;
	} sqrt_req_t;
endpackage
`default_nettype wire

// ===== rtl/core/tpr_serial_mul.sv =====
// ----------------------------------------------------------------------------
// tpr_serial_mul
// Shift-and-add multiplier, one multiplier bit per cycle, 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none
module tpr_serial_mul
	import tpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mul_req_t    req,
	output logic             done,
	output logic [63:0]      prod
);
	logic [63:0] mcand_q;
	logic [63:0] mplier_q;
	logic [63:0] acc_q;
	logic [6:0]  cnt_q;
	logic        busy_q;

	// One bit of the multiplier consumed per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q  <= req.a;
			mplier_q <= req.b;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[62:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[63:1]};
		end
	end

	assign prod = acc_q;
endmodule
`default_nettype wire

// ===== rtl/core/tpr_serial_sqrt.sv =====
// ----------------------------------------------------------------------------
// tpr_serial_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tpr_serial_sqrt
	import tpr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sqrt_req_t   req,
	output logic             done,
	output logic [31:0]      root
);
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [33:0] trial;
	logic [33:0] rem_sh;

	// Bring down two radicand bits and try the next root bit
	assign rem_sh = {rem_q[31:0], rad_q[63:62]};
	assign trial  = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule
`default_nettype wire

// ===== rtl/core/trapezoidal_position_ramp_core.sv =====
// ----------------------------------------------------------------------------
// trapezoidal_position_ramp_core
// Trapezoidal velocity profile generator with serial multiply and square root.
// ----------------------------------------------------------------------------
// Usage: an input transaction (target_position, time_step) on in_valid/in_ready
// produces one output transaction (position, velocity) on out_valid/out_ready.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, which the core does not enforce. Index 3 is ignored
// and the data port carries the 31 register bits. One transaction at a time.
// The shared bit-serial multiplier is used four times: |E|*2D, V*V, A*dt and
// |V|*dt, and the serial square root runs when the braking curve applies and
// the error is not below SMALL_ERR. in_ready returns in the same cycle that
// the result is loaded into the output register.
// The result sits in an output register; the next input is accepted once the
// result is loaded there, even while the receiver stalls, but the following
// result waits until the held one is taken, and input waits behind it.
// Reset clears position and velocity to zero and the limits to 1.0.
`default_nettype none
module trapezoidal_position_ramp_core
	import tpr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] target_position,
	input  wire logic [15:0]        time_step,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      position,
	output logic signed [31:0]      velocity
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_M_ED  = 4'd1;
	localparam logic [3:0] ST_M_VV  = 4'd2;
	localparam logic [3:0] ST_DEC   = 4'd3;
	localparam logic [3:0] ST_SQRT  = 4'd4;
	localparam logic [3:0] ST_M_AD  = 4'd5;
	localparam logic [3:0] ST_VEL   = 4'd6;
	localparam logic [3:0] ST_M_PD  = 4'd7;
	localparam logic [3:0] ST_POS   = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0]          state_q;
	logic [CfgW-1:0]     vlim_q, alim_q, dlim_q;
	logic signed [31:0]  pos_q, vel_q;
	logic signed [32:0]  err_q;
	logic [15:0]         dt_q;
	logic [63:0]         ed_q;
	logic signed [33:0]  sp_q;
	logic                mstart_q, sstart_q;
	logic [63:0]         ma_q, mb_q;
	mul_req_t            mreq;
	sqrt_req_t           sreq;
	logic                mdone, sdone;
	logic [63:0]         prod;
	logic [31:0]         root;
	logic [32:0]         aerr;
	logic [31:0]         avel;
	logic signed [34:0]  verr;
	logic signed [34:0]  vnew;
	logic [63:0]         dp;
	logic signed [33:0]  pnew;
	logic signed [32:0]  ein;
	logic [32:0]         ain;

	assign aerr = err_q[32] ? 33'(-err_q) : 33'(err_q);
	assign avel = vel_q[31] ? 32'(-vel_q) : 32'(vel_q);
	assign verr = 35'(sp_q) - 35'(vel_q);
	assign dp   = prod >> 16;
	assign pnew = vel_q[31] ? 34'(pos_q) - 34'(dp[33:0]) : 34'(pos_q) + 34'(dp[33:0]);

	// error of the incoming target and its magnitude
	assign ein = 33'(target_position) - 33'(pos_q);
	assign ain = ein[32] ? 33'(-ein) : 33'(ein);

	assign mreq = '{start: mstart_q, a: ma_q, b: mb_q};
	assign sreq = '{start: sstart_q, x: ed_q};

	tpr_serial_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .done(mdone), .prod(prod));
	tpr_serial_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sreq), .done(sdone), .root(root));

	assign in_ready = (state_q == ST_IDLE);

	// Velocity step toward the set point, limit in prod
	always_comb begin
		logic [34:0] mag;
		mag = verr[34] ? 35'(-verr) : 35'(verr);
		if (mag > 35'(prod[63:16]))
			vnew = verr[34] ? 35'(vel_q) - 35'(prod[63:16])
				: 35'(vel_q) + 35'(prod[63:16]);
		else
			vnew = 35'(sp_q);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlim_q <= CFG_RESET;
			alim_q <= CFG_RESET;
			dlim_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VEL_LIMIT: vlim_q <= cfg_data;
				REG_ACC_LIMIT: alim_q <= cfg_data;
				REG_DEC_LIMIT: dlim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			vel_q     <= '0;
			out_valid <= 1'b0;
			mstart_q  <= 1'b0;
			sstart_q  <= 1'b0;
			err_q     <= '0;
			dt_q      <= '0;
			ed_q      <= '0;
			sp_q      <= '0;
			ma_q      <= '0;
			mb_q      <= '0;
			position  <= '0;
			velocity  <= '0;
		end else begin
			mstart_q <= 1'b0;
			sstart_q <= 1'b0;
			if (out_valid && out_ready && state_q != ST_OUT)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						err_q    <= ein;
						dt_q     <= time_step;
						state_q  <= ST_M_ED;
						mstart_q <= 1'b1;
						ma_q     <= 64'(ain);
						mb_q     <= 64'({dlim_q, 1'b0});
					end
				end
				ST_M_ED: begin
					// wait for |E|*2D, then square the velocity
					if (mdone) begin
						ed_q     <= prod;
						state_q  <= ST_M_VV;
						mstart_q <= 1'b1;
						ma_q     <= 64'(avel);
						mb_q     <= 64'(avel);
					end
				end
				ST_M_VV: begin
					if (mdone) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (ed_q <= prod) begin
						if (64'(aerr) < SMALL_ERR) begin
							sp_q     <= 34'(err_q) <<< 1;
							state_q  <= ST_M_AD;
							mstart_q <= 1'b1;
						end else begin
							sstart_q <= 1'b1;
							state_q  <= ST_SQRT;
						end
					end else begin
						sp_q     <= err_q[32] ? -34'(vlim_q)
							: (err_q == '0 ? '0 : 34'(vlim_q));
						state_q  <= ST_M_AD;
						mstart_q <= 1'b1;
					end
					ma_q <= 64'(alim_q);
					mb_q <= 64'(dt_q);
				end
				ST_SQRT: begin
					if (sdone) begin
						sp_q     <= err_q[32] ? -34'(root) : 34'(root);
						state_q  <= ST_M_AD;
						mstart_q <= 1'b1;
					end
				end
				ST_M_AD: begin
					if (mdone) state_q <= ST_VEL;
				end
				ST_VEL: begin
					if (vnew > 35'sd2147483647)
						vel_q <= 32'sh7FFFFFFF;
					else if (vnew < -35'sd2147483648)
						vel_q <= 32'sh80000000;
					else
						vel_q <= vnew[31:0];
					state_q <= ST_M_PD;
				end
				ST_M_PD: begin
					// vel_q updated; launch |V|*dt
					ma_q     <= 64'(avel);
					mb_q     <= 64'(dt_q);
					mstart_q <= 1'b1;
					state_q  <= ST_POS;
				end
				ST_POS: begin
					if (mdone) begin
						if (pnew > 34'sd2147483647)
							pos_q <= 32'sh7FFFFFFF;
						else if (pnew < -34'sd2147483648)
							pos_q <= 32'sh80000000;
						else
							pos_q <= pnew[31:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						position  <= pos_q;
						velocity  <= vel_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/tpr_checker.sv =====
// ----------------------------------------------------------------------------
// tpr_checker
// Port-level checks on the ramp core handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "trapezoidal_position_ramp_core_assert.svh"
module tpr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] position,
	input wire logic [31:0] velocity
);
	// A stalled result holds its value
	`TPR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(position) && $stable(velocity), "result changed under stall")
	// An accepted transaction leaves the core busy next cycle
	`TPR_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "core ready right after accept")
	// With no result pending, none appears in the cycle after acceptance
	`TPR_ASSERT_NEXT(a_no_early, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid, "result too early")
endmodule

bind trapezoidal_position_ramp_core tpr_checker u_tpr_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .position(position),
	.velocity(velocity)
);
`default_nettype wire
